/* rtl/cfc_pkg.sv */
package cfc_pkg;

  // default chain capacity
  localparam int DEF_MAX_LINKS = 16;

  // register reset values
  localparam logic [4:0]  NUM_LINKS_RST   = 5'd15;
  localparam logic [30:0] LINK_LENGTH_RST = 31'd65536;
  localparam logic        LAYOUT_MODE_RST = 1'b0;

  // register indexes
  localparam logic [1:0] CFG_NUM_LINKS   = 2'd0;
  localparam logic [1:0] CFG_LINK_LENGTH = 2'd1;
  localparam logic [1:0] CFG_LAYOUT_MODE = 2'd2;

  // commands
  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // layouts
  localparam logic LAYOUT_STRAIGHT = 1'b0;

  // shift-subtract unit widths and step counts
  localparam int RAD_W      = 66;  // radicand / shifted dividend
  localparam int ROOT_W     = 33;
  localparam int DVS_W      = 34;
  localparam int ACC_W      = 36;
  localparam int RES_W      = 64;
  localparam int MAG_W      = 33;
  localparam int CNT_W      = 7;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 64;

  typedef enum logic {OP_SQRT, OP_DIV} iter_op_t;

  typedef struct packed {
    logic               go;
    iter_op_t           op;
    logic [RAD_W-1:0]   src;
    logic [DVS_W-1:0]   divisor;
  } iter_req_t;

endpackage

/* rtl/cfc_iter.sv */
// Shared shift-subtract unit: integer square root, two radicand bits per
// step, or restoring division, one dividend bit per step.
module cfc_iter (
  input  logic                            clk,
  input  logic                            rst,
  input  cfc_pkg::iter_req_t              req,
  output logic                            done,
  output logic [cfc_pkg::RES_W-1:0]       res
);

  logic                          busy;
  cfc_pkg::iter_op_t             op;
  logic [cfc_pkg::RAD_W-1:0]     src;
  logic [cfc_pkg::DVS_W-1:0]     dvs;
  logic [cfc_pkg::ACC_W-1:0]     acc;
  logic [cfc_pkg::CNT_W-1:0]     cnt;
  logic [cfc_pkg::ACC_W-1:0]     cand;
  logic [cfc_pkg::ACC_W-1:0]     trial;
  logic                          ge;

  // candidate remainder and trial subtrahend for this step
  always_comb begin
    if (op == cfc_pkg::OP_SQRT) begin
      cand  = {acc[cfc_pkg::ACC_W-3:0], src[cfc_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, res[cfc_pkg::ROOT_W-1:0], 2'b01};
    end else begin
      cand  = {acc[cfc_pkg::ACC_W-2:0], src[cfc_pkg::RAD_W-1]};
      trial = {2'b00, dvs};
    end
    ge = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        op   <= req.op;
        src  <= req.src;
        dvs  <= req.divisor;
        acc  <= '0;
        res  <= '0;
        cnt  <= (req.op == cfc_pkg::OP_SQRT) ? cfc_pkg::CNT_W'(cfc_pkg::SQRT_STEPS - 1)
                                             : cfc_pkg::CNT_W'(cfc_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        acc <= ge ? (cand - trial) : cand;
        res <= {res[cfc_pkg::RES_W-2:0], ge};
        src <= (op == cfc_pkg::OP_SQRT) ? {src[cfc_pkg::RAD_W-3:0], 2'b00}
                                        : {src[cfc_pkg::RAD_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/cfc_seq.sv */
// Chain sequencer: point memory, shared multiplier, link-by-link walk.
module cfc_seq #(
  parameter int MAX_LINKS = cfc_pkg::DEF_MAX_LINKS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [31:0]        anchor_x,
  input  logic [31:0]        anchor_y,
  input  logic [31:0]        anchor_z,
  input  logic [31:0]        step_x,
  input  logic [31:0]        step_y,
  input  logic [31:0]        step_z,
  input  logic [4:0]         num_links,
  input  logic [30:0]        link_length,
  input  logic               layout_mode,
  output logic               result_valid,
  output logic [3:0]         link_index,
  output logic [31:0]        pos_x,
  output logic [31:0]        pos_y,
  output logic [31:0]        pos_z,
  output logic [31:0]        dir_x,
  output logic [31:0]        dir_y,
  output logic [31:0]        dir_z,
  output logic               last
);

  localparam int AW = (MAX_LINKS + 1 > 1) ? $clog2(MAX_LINKS + 1) : 1;
  localparam int MW = cfc_pkg::MAG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD, S_DIFF, S_SQ, S_ACC, S_RT_GO, S_RT_WAIT,
    S_MUL, S_DV_GO, S_DV_WAIT, S_EMIT
  } state_t;

  state_t             state;
  logic               layout;
  logic [30:0]        ll;
  logic [AW-1:0]      n;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      nxt;
  logic [31:0]        anc  [3];
  logic [31:0]        stp  [3];
  logic [31:0]        prev [3];
  logic [31:0]        newp [3];
  logic [MW-1:0]      mag  [3];
  logic               neg  [3];
  logic [1:0]         ax;
  logic [65:0]        sum;
  logic [65:0]        prod;
  logic [32:0]        len;

  // point memory, one word holds x, y, z
  logic [95:0]        mem [MAX_LINKS+1];
  logic [MAX_LINKS:0] vld;
  logic [95:0]        rd_data;
  logic               rd_ok;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [95:0]        wr_data;

  logic [31:0]        in_anc [3];
  logic [31:0]        in_stp [3];
  logic [31:0]        init_pt [3];
  logic [31:0]        emit_pt [3];
  logic [31:0]        cur [3];
  logic [32:0]        dif [3];
  logic [MW-1:0]      mul_a;
  logic [MW-1:0]      mul_b;
  logic [65:0]        mul_p;
  logic [31:0]        quo;
  logic [31:0]        off;
  logic [AW-1:0]      n_cap;

  cfc_pkg::iter_req_t             req;
  logic                           it_done;
  logic [cfc_pkg::RES_W-1:0]      it_res;

  cfc_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (it_done),
    .res  (it_res)
  );

  assign busy = (state != S_IDLE);
  assign nxt  = idx + AW'(1);

  assign in_anc[0] = anchor_x;
  assign in_anc[1] = anchor_y;
  assign in_anc[2] = anchor_z;
  assign in_stp[0] = step_x;
  assign in_stp[1] = step_y;
  assign in_stp[2] = step_z;

  // links in use, saturated to capacity
  assign n_cap = (int'(num_links) > MAX_LINKS) ? AW'(MAX_LINKS) : AW'(num_links);

  // per-axis layout, difference and stored point
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (layout == cfc_pkg::LAYOUT_STRAIGHT) begin
        init_pt[k] = prev[k] + stp[k];
      end else if (nxt[0]) begin
        init_pt[k] = anc[k] + stp[k];
      end else begin
        init_pt[k] = anc[k];
      end
      emit_pt[k] = (state == S_INIT) ? init_pt[k] : newp[k];
      cur[k]     = rd_ok ? rd_data[32*k +: 32] : 32'd0;
      dif[k]     = {cur[k][31], cur[k]} - {prev[k][31], prev[k]};
    end
  end

  // shared multiplier: squares, then magnitude times link length
  assign mul_a = mag[ax];
  assign mul_b = (state == S_SQ) ? mag[ax] : {2'b00, ll};
  assign mul_p = {33'd0, mul_a} * {33'd0, mul_b};

  // signed offset from truncated quotient
  assign quo = it_res[31:0];
  assign off = neg[ax] ? (32'd0 - quo) : quo;

  // requests to the shift-subtract unit
  always_comb begin
    req.go      = (state == S_RT_GO) || (state == S_DV_GO);
    req.op      = (state == S_RT_GO) ? cfc_pkg::OP_SQRT : cfc_pkg::OP_DIV;
    req.src     = (state == S_RT_GO) ? sum : {prod[63:0], 2'b00};
    req.divisor = {1'b0, len};
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = nxt;
    wr_data = {emit_pt[2], emit_pt[1], emit_pt[0]};
    if (state == S_IDLE) begin
      wr_en   = start;
      wr_addr = '0;
      wr_data = {anchor_z, anchor_y, anchor_x};
    end else if (state == S_INIT || state == S_EMIT) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[nxt];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vld          <= '0;
      rd_ok        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_ok        <= vld[nxt];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            layout <= layout_mode;
            ll     <= link_length;
            n      <= n_cap;
            idx    <= '0;
            for (int k = 0; k < 3; k++) begin
              anc[k]  <= in_anc[k];
              stp[k]  <= in_stp[k];
              prev[k] <= in_anc[k];
            end
            if (n_cap == '0) begin
              state <= S_IDLE;
            end else if (command == cfc_pkg::CMD_INIT) begin
              state <= S_INIT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= dif[k][32];
            mag[k] <= dif[k][32] ? (33'd0 - dif[k]) : dif[k];
          end
          sum   <= '0;
          ax    <= 2'd0;
          state <= S_SQ;
        end
        S_SQ: begin
          prod  <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum + prod;
          if (ax == 2'd2) begin
            state <= S_RT_GO;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_SQ;
          end
        end
        S_RT_GO: begin
          state <= S_RT_WAIT;
        end
        S_RT_WAIT: begin
          if (it_done) begin
            len <= it_res[32:0];
            ax  <= 2'd0;
            if (it_res[32:0] == 33'd0) begin
              for (int k = 0; k < 3; k++) begin
                newp[k] <= prev[k];
              end
              state <= S_EMIT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_DV_GO;
        end
        S_DV_GO: begin
          state <= S_DV_WAIT;
        end
        S_DV_WAIT: begin
          if (it_done) begin
            newp[ax] <= prev[ax] + off;
            if (ax == 2'd2) begin
              state <= S_EMIT;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_INIT, S_EMIT: begin
          result_valid <= 1'b1;
          link_index   <= 4'(idx);
          last         <= (nxt == n);
          pos_x        <= prev[0];
          pos_y        <= prev[1];
          pos_z        <= prev[2];
          dir_x        <= emit_pt[0] - prev[0];
          dir_y        <= emit_pt[1] - prev[1];
          dir_z        <= emit_pt[2] - prev[2];
          for (int k = 0; k < 3; k++) begin
            prev[k] <= emit_pt[k];
          end
          idx <= nxt;
          if (nxt == n) begin
            state <= S_IDLE;
          end else if (state == S_INIT) begin
            state <= S_INIT;
          end else begin
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/chain_follow_constraint.sv */
// Follow-the-leader chain of 3D points, signed Q16.16.
// Command channel: a command is taken on a clock edge with start high and
// busy low. command 0 lays the chain out from the anchor and step offset,
// command 1 moves point 0 to the anchor and pulls every later point to
// link_length from its predecessor.
// Results: one beat per link in use, in link order, each on the result
// ports for one cycle with result_valid high; last marks the final link.
// The receiver cannot stall; every beat must be taken when shown.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while busy is low. Index 0 num_links, 1 link_length, 2 layout_mode.
// Sequence: a layout command writes one point per link. An update walks
// the links in order: the shared shift-subtract unit spends 33 steps on
// the square root and 64 steps on each of three divides, and the shared
// multiplier forms the three squares one at a time. busy falls in the
// cycle the last beat is shown, so the next command can be taken then.
// A zero link count gives no beats.
// Reset: points read as zero, registers return to 15 links, length 1.0,
// straight layout; the block is ready in the next cycle.
module chain_follow_constraint #(
  parameter int MAX_LINKS = cfc_pkg::DEF_MAX_LINKS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic         command,
  input  logic [31:0]  anchor_x,
  input  logic [31:0]  anchor_y,
  input  logic [31:0]  anchor_z,
  input  logic [31:0]  step_x,
  input  logic [31:0]  step_y,
  input  logic [31:0]  step_z,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         result_valid,
  output logic [3:0]   link_index,
  output logic [31:0]  pos_x,
  output logic [31:0]  pos_y,
  output logic [31:0]  pos_z,
  output logic [31:0]  dir_x,
  output logic [31:0]  dir_y,
  output logic [31:0]  dir_z,
  output logic         last
);

  logic [4:0]  num_links;
  logic [30:0] link_length;
  logic        layout_mode;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_links   <= cfc_pkg::NUM_LINKS_RST;
      link_length <= cfc_pkg::LINK_LENGTH_RST;
      layout_mode <= cfc_pkg::LAYOUT_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfc_pkg::CFG_NUM_LINKS:   num_links   <= cfg_data[4:0];
        cfc_pkg::CFG_LINK_LENGTH: link_length <= cfg_data[30:0];
        cfc_pkg::CFG_LAYOUT_MODE: layout_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cfc_seq #(
    .MAX_LINKS (MAX_LINKS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .anchor_x     (anchor_x),
    .anchor_y     (anchor_y),
    .anchor_z     (anchor_z),
    .step_x       (step_x),
    .step_y       (step_y),
    .step_z       (step_z),
    .num_links    (num_links),
    .link_length  (link_length),
    .layout_mode  (layout_mode),
    .result_valid (result_valid),
    .link_index   (link_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .last         (last)
  );

endmodule

/* tb/chain_follow_constraint_checker.sv */
module chain_follow_constraint_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [31:0] anchor_x,
  input  logic [31:0] anchor_y,
  input  logic [31:0] anchor_z,
  input  logic [31:0] step_x,
  input  logic [31:0] step_y,
  input  logic [31:0] step_z,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        result_valid,
  input  logic [3:0]  link_index,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic        last,
  output int          pending,
  output int          errors
);

  localparam int CAP = cfc_pkg::DEF_MAX_LINKS;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] px, py, pz;
    logic [31:0] dx, dy, dz;
    logic        lst;
  } link_beat_t;

  link_beat_t  link_beat_q[$];
  logic [31:0] chain_x [0:CAP];
  logic [31:0] chain_y [0:CAP];
  logic [31:0] chain_z [0:CAP];
  logic [4:0]  links_reg;
  logic [30:0] length_reg;
  logic        layout_reg;

  // floor square root of a sum of three 66-bit squares
  function automatic logic [34:0] floor_root(logic [69:0] n);
    logic [34:0] r;
    logic [34:0] c;
    logic [69:0] sq;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      sq = {35'd0, c} * {35'd0, c};
      if (sq <= n) r = c;
    end
    return r;
  endfunction

  // move one axis from its predecessor by |d|*length/len with the sign of d
  function automatic logic [31:0] pull_axis(logic [31:0] prev, logic signed [32:0] d,
                                            logic [32:0] m, logic [34:0] len);
    logic [63:0] q;
    logic [31:0] off;
    q = ({31'd0, m} * {33'd0, length_reg}) / {29'd0, len};
    off = q[31:0];
    if (d < 0) off = -off;
    return prev + off;
  endfunction

  function automatic logic signed [32:0] axis_diff(logic [31:0] a, logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  task automatic apply_command(logic cmd, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                               logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    int n;
    logic signed [32:0] ddx, ddy, ddz;
    logic [32:0] mx, my, mz;
    logic [69:0] sum;
    logic [34:0] len;
    link_beat_t bt;
    n = (links_reg > CAP) ? CAP : links_reg;
    chain_x[0] = ax;
    chain_y[0] = ay;
    chain_z[0] = az;
    if (cmd == cfc_pkg::CMD_INIT) begin
      for (int i = 1; i <= n; i++) begin
        if (layout_reg == cfc_pkg::LAYOUT_STRAIGHT) begin
          chain_x[i] = chain_x[i-1] + sx;
          chain_y[i] = chain_y[i-1] + sy;
          chain_z[i] = chain_z[i-1] + sz;
        end else if (i % 2 == 1) begin
          chain_x[i] = ax + sx;
          chain_y[i] = ay + sy;
          chain_z[i] = az + sz;
        end else begin
          chain_x[i] = ax;
          chain_y[i] = ay;
          chain_z[i] = az;
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        ddx = axis_diff(chain_x[i+1], chain_x[i]);
        ddy = axis_diff(chain_y[i+1], chain_y[i]);
        ddz = axis_diff(chain_z[i+1], chain_z[i]);
        mx = (ddx < 0) ? -ddx : ddx;
        my = (ddy < 0) ? -ddy : ddy;
        mz = (ddz < 0) ? -ddz : ddz;
        sum = {37'd0, mx} * {37'd0, mx} + {37'd0, my} * {37'd0, my}
            + {37'd0, mz} * {37'd0, mz};
        len = floor_root(sum);
        // coincident points: follower lands on its predecessor
        if (len == 0) begin
          chain_x[i+1] = chain_x[i];
          chain_y[i+1] = chain_y[i];
          chain_z[i+1] = chain_z[i];
        end else begin
          chain_x[i+1] = pull_axis(chain_x[i], ddx, mx, len);
          chain_y[i+1] = pull_axis(chain_y[i], ddy, my, len);
          chain_z[i+1] = pull_axis(chain_z[i], ddz, mz, len);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      bt.idx = i[3:0];
      bt.px = chain_x[i];
      bt.py = chain_y[i];
      bt.pz = chain_z[i];
      bt.dx = chain_x[i+1] - chain_x[i];
      bt.dy = chain_y[i+1] - chain_y[i];
      bt.dz = chain_z[i+1] - chain_z[i];
      bt.lst = (i + 1 == n);
      link_beat_q.push_back(bt);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    link_beat_t w;
    if (rst) begin
      for (int i = 0; i <= CAP; i++) begin
        chain_x[i] = '0;
        chain_y[i] = '0;
        chain_z[i] = '0;
      end
      links_reg = cfc_pkg::NUM_LINKS_RST;
      length_reg = cfc_pkg::LINK_LENGTH_RST;
      layout_reg = cfc_pkg::LAYOUT_MODE_RST;
      link_beat_q.delete();
      errors = 0;
    end else begin
      // result beat against the oldest expectation
      if (result_valid) begin
        if (link_beat_q.size() == 0) begin
          $error("unexpected result beat, link_index %0d", link_index);
          errors++;
        end else begin
          w = link_beat_q.pop_front();
          check_field("link_index", w.idx, link_index);
          check_field("pos_x", w.px, pos_x);
          check_field("pos_y", w.py, pos_y);
          check_field("pos_z", w.pz, pos_z);
          check_field("dir_x", w.dx, dir_x);
          check_field("dir_y", w.dy, dir_y);
          check_field("dir_z", w.dz, dir_z);
          check_field("last", w.lst, last);
        end
      end
      // accepted command sees the registers as they were before this edge
      if (start && !busy)
        apply_command(command, anchor_x, anchor_y, anchor_z, step_x, step_y, step_z);
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfc_pkg::CFG_NUM_LINKS:   links_reg = cfg_data[4:0];
          cfc_pkg::CFG_LINK_LENGTH: length_reg = cfg_data[30:0];
          cfc_pkg::CFG_LAYOUT_MODE: layout_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= link_beat_q.size();
  end

endmodule

/* tb/chain_follow_constraint_test.sv */
module chain_follow_constraint_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = cfc_pkg::CMD_INIT;
  logic [31:0] anchor_x = '0, anchor_y = '0, anchor_z = '0;
  logic [31:0] step_x = '0, step_y = '0, step_z = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = cfc_pkg::CFG_NUM_LINKS;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  logic [3:0]  link_index;
  logic [31:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
  logic        last;
  int          pending;
  int          errors;
  int          cycles = 0;
  int          sent = 0;
  bit          calm = 1'b0;

  localparam int CYCLE_LIMIT = 3000000;

  always #5 clk = ~clk;

  chain_follow_constraint i_dut (.*);

  chain_follow_constraint_checker i_chk (.*);

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("chain_follow_constraint verification failed");
      $finish;
    end
  end

  // wait for the block to drain, with slack for commands that emit nothing
  task automatic drain();
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_chain(int links, logic [30:0] len, logic mode);
    drain();
    write_reg(cfc_pkg::CFG_NUM_LINKS, 32'(links));
    write_reg(cfc_pkg::CFG_LINK_LENGTH, {$urandom} & 32'h8000_0000 | {1'b0, len});
    write_reg(cfc_pkg::CFG_LAYOUT_MODE, {$urandom} & 32'hffff_fffe | {31'd0, mode});
  endtask

  // one command beat; start stays high when the next beat follows directly
  task automatic send(logic cmd, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                      logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    if (!calm && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    anchor_x <= ax; anchor_y <= ay; anchor_z <= az;
    step_x <= sx; step_y <= sy; step_z <= sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic idle_start();
    start <= 1'b0;
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic int pick_links();
    case ($urandom_range(9))
      0: return 16;
      1: return $urandom_range(17, 31);
      2: return 0;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic logic [30:0] pick_length();
    case ($urandom_range(5))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom);
      default: return 31'($urandom_range(1, 32'h0008_0000));
    endcase
  endfunction

  initial begin
    logic [31:0] ax, ay, az;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, extremes, coincident points, both layouts
    send(cfc_pkg::CMD_UPDATE, '0, '0, '0, '0, '0, '0);
    send(cfc_pkg::CMD_INIT, 32'h7fff_ffff, 32'h8000_0000, '0, 32'h0001_0000, '0, '0);
    send(cfc_pkg::CMD_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '0, '0, '0);
    idle_start();
    set_chain(4, 31'h7fff_ffff, 1'b1);
    send(cfc_pkg::CMD_INIT, 32'h1234_0000, '0, 32'h8000_0000, 32'h7fff_ffff,
         32'h8000_0000, 32'hffff_ffff);
    send(cfc_pkg::CMD_UPDATE, 32'h1234_0000, '0, 32'h8000_0000, '0, '0, '0);
    send(cfc_pkg::CMD_INIT, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, '0, '0, '0);
    send(cfc_pkg::CMD_UPDATE, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, '0, '0, '0);
    idle_start();
    set_chain(0, 31'd0, 1'b0);
    send(cfc_pkg::CMD_INIT, 32'hdead_beef, 32'h0bad_f00d, 32'h1111_1111, 32'h1, 32'h2,
         32'h3);
    send(cfc_pkg::CMD_UPDATE, 32'h1, 32'h2, 32'h3, '0, '0, '0);
    idle_start();
    set_chain(16, 31'd0, 1'b0);
    send(cfc_pkg::CMD_INIT, '0, '0, '0, 32'hffff_0000, 32'h0003_0000, 32'h8000_0000);
    send(cfc_pkg::CMD_UPDATE, 32'h0010_0000, '0, '0, '0, '0, '0);
    idle_start();
    set_chain(31, 31'h0001_8000, 1'b1);
    send(cfc_pkg::CMD_INIT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h7fff_ffff);
    send(cfc_pkg::CMD_UPDATE, '0, '0, '0, '0, '0, '0);
    idle_start();
    set_chain(1, 31'd65536, 1'b0);
    send(cfc_pkg::CMD_INIT, '0, '0, '0, 32'h0003_0000, 32'h0004_0000, '0);
    send(cfc_pkg::CMD_UPDATE, '0, '0, '0, '0, '0, '0);

    // random phases: a layout, then the anchor wanders with a few relayouts
    while (sent < 175) begin
      idle_start();
      set_chain(pick_links(), pick_length(), 1'($urandom_range(1)));
      calm = (sent > 80 && sent < 120);
      ax = coord(); ay = coord(); az = coord();
      send(cfc_pkg::CMD_INIT, ax, ay, az, coord(), coord(), coord());
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(9) == 0) begin
          send(cfc_pkg::CMD_INIT, coord(), coord(), coord(), coord(), coord(), coord());
        end else begin
          if ($urandom_range(3) == 0) begin
            ax = coord(); ay = coord(); az = coord();
          end else begin
            ax += $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            ay += $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
          end
          send(cfc_pkg::CMD_UPDATE, ax, ay, az, $urandom, $urandom, $urandom);
        end
        // hold off until the chain has fully reported
        if ($urandom_range(19) == 0) begin
          idle_start();
          drain();
        end
      end
    end
    idle_start();

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("chain_follow_constraint verification clean");
    end else begin
      $display("chain_follow_constraint verification failed");
    end
    $finish;
  end

endmodule
